// ===== design/aes_ctr_pkg.sv =====
// Package for the AES-256 counter-mode keystream block.
// Holds register codes, the S-box function and GF(2^8) helpers; no dependencies.
`timescale 1ns / 1ps

package aes_ctr_pkg;

    localparam int RoundCount    = 14;
    localparam int CfgIndexWidth = 3;

    typedef enum logic [CfgIndexWidth-1:0] {
        REG_KEY_WORD_0         = 3'd0,
        REG_KEY_WORD_1         = 3'd1,
        REG_KEY_WORD_2         = 3'd2,
        REG_KEY_WORD_3         = 3'd3,
        REG_COUNTER_START_HIGH = 3'd4,
        REG_COUNTER_START_LOW  = 3'd5
    } cfg_reg_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    // Byte j of a 128-bit block sits at bits [127-8j -: 8].
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[127 - 8*(c*4 + r) -: 8] = sbox(s[127 - 8*((((c + r) & 3) * 4) + r) -: 8]);
        return t;
    endfunction

    function automatic logic [127:0] mix_cols(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0]   a0, a1, a2, a3, all;
        for (int c = 0; c < 4; c++) begin
            a0  = s[127 - 32*c -: 8];
            a1  = s[119 - 32*c -: 8];
            a2  = s[111 - 32*c -: 8];
            a3  = s[103 - 32*c -: 8];
            all = a0 ^ a1 ^ a2 ^ a3;
            t[127 - 32*c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
            t[119 - 32*c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
            t[111 - 32*c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
            t[103 - 32*c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
        end
        return t;
    endfunction

endpackage

// ===== design/aes256_ctr_keystream.sv =====
// AES-256 CTR keystream block: top level with key expansion and shared round unit.
// Key write: expansion of the remaining words, one 32-bit word per cycle, before the block is idle.
// Data request: add-key at accept, then 14 rounds one per cycle, then a registered output state.
// Next request is taken in the cycle the result leaves; no new request while one is in progress.
// A zero byte count skips the cipher; its result is registered at accept and valid in the next cycle.
// Reset (rst_n, async low): key, round keys and counter cleared to zero; output empty.
`timescale 1ns / 1ps

module aes256_ctr_keystream
    import aes_ctr_pkg::*;
#(
    parameter int ROUND_COUNT = RoundCount
)(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // data_high[63:0], data_low[127:64], byte_count[132:128], zero pad
    input  logic [135:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // result_high, result_low, counter_now_high, counter_now_low (low bits first)
    output logic [255:0] m_tdata
);

    localparam int StoreDepth = 2 * (ROUND_COUNT + 1);
    localparam int ExpWords   = 4 * (ROUND_COUNT + 1);
    localparam int RndW       = $clog2(ROUND_COUNT + 1);
    localparam int WordW      = $clog2(ExpWords);

    typedef enum logic [1:0] {ST_IDLE, ST_EXPAND, ST_ROUND, ST_OUT} state_t;

    state_t          state_reg;
    logic [63:0]     rk_mem [StoreDepth];
    logic [63:0]     key_reg [4];
    logic [255:0]    win_reg;          // last 8 expansion words, word i-8 at top
    logic [WordW-1:0] wi_reg;          // expansion word index
    logic [7:0]      rcon_reg;
    logic [31:0]     whi_reg;          // first half of a 64-bit store entry
    logic [127:0]    st_reg, ctr_reg, din_reg;
    logic [4:0]      cnt_reg;
    logic [RndW-1:0] rnd_reg;
    logic [255:0]    out_reg;
    logic            outv_reg;

    // round key read: the two entries of round rnd are read together, combinationally
    logic [127:0]    rk_cur;
    assign rk_cur = {rk_mem[{rnd_reg, 1'b0}], rk_mem[{rnd_reg, 1'b1}]};

    // key expansion word
    logic [31:0] t_w, w_new;
    always_comb
    begin
        t_w = win_reg[31:0];
        if (wi_reg[2:0] == 3'd0)
            t_w = sub_word({t_w[23:0], t_w[31:24]}) ^ {rcon_reg, 24'd0};
        else if (wi_reg[2:0] == 3'd4)
            t_w = sub_word(t_w);
        w_new = win_reg[255:224] ^ t_w;
    end

    logic [4:0]   n_sat;
    logic [127:0] mask, ks, rnd_in;
    assign n_sat = (s_tdata[132:128] > 5'd16) ? 5'd16 : s_tdata[132:128];
    always_comb
    begin
        for (int j = 0; j < 16; j++)
            mask[127 - 8*j -: 8] = (5'(j) < cnt_reg) ? 8'hff : 8'h00;
        rnd_in = sub_shift(st_reg);
        if (rnd_reg != RndW'(ROUND_COUNT))
            rnd_in = mix_cols(rnd_in);
        ks = rnd_in ^ rk_cur;
    end

    // processed bytes, high half at top
    logic [127:0] res_blk;
    assign res_blk = (din_reg ^ st_reg) & mask;

    logic [127:0] ctr_inc;
    assign ctr_inc = ctr_reg + 128'd1;

    // load the output register: finished cipher or zero-count request
    logic out_load;

    assign cfg_ready = (state_reg == ST_IDLE);
    // hold off requests while a config write is offered; pass through a draining result
    assign s_tready  = (state_reg == ST_IDLE) && !cfg_valid && (!outv_reg || m_tready);
    assign out_load  = (state_reg == ST_OUT) || (s_tvalid && s_tready && (n_sat == 5'd0));
    assign m_tvalid  = outv_reg;
    assign m_tdata   = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            outv_reg  <= 1'b0;
            ctr_reg   <= '0;
            for (int i = 0; i < 4; i++) key_reg[i] <= '0;
            for (int i = 0; i < StoreDepth; i++) rk_mem[i] <= '0;
            wi_reg <= '0; rcon_reg <= 8'h01; rnd_reg <= '0;
        end else begin
            if (out_load)
                outv_reg <= 1'b1;
            else if (m_tready)
                outv_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cfg_valid) begin
                        case (cfg_index) inside
                            REG_KEY_WORD_0, REG_KEY_WORD_1, REG_KEY_WORD_2, REG_KEY_WORD_3:
                            begin
                                key_reg[cfg_index[1:0]] <= cfg_data;
                                // load the window with the key, newest write applied
                                for (int i = 0; i < 4; i++)
                                    win_reg[255 - 64*i -: 64] <=
                                        (2'(i) == cfg_index[1:0]) ? cfg_data : key_reg[i];
                                for (int i = 0; i < 4; i++)
                                    rk_mem[i] <=
                                        (2'(i) == cfg_index[1:0]) ? cfg_data : key_reg[i];
                                wi_reg    <= WordW'(8);
                                rcon_reg  <= 8'h01;
                                state_reg <= ST_EXPAND;
                            end
                            REG_COUNTER_START_HIGH: ctr_reg[127:64] <= cfg_data;
                            REG_COUNTER_START_LOW:  ctr_reg[63:0]   <= cfg_data;
                            default: ;
                        endcase
                    end else if (s_tvalid && s_tready) begin
                        din_reg <= {s_tdata[63:0], s_tdata[127:64]};
                        cnt_reg <= n_sat;
                        if (n_sat == 5'd0) begin
                            out_reg  <= {ctr_reg[63:0], ctr_reg[127:64], 128'd0};
                        end else begin
                            st_reg    <= ctr_reg ^ {rk_mem[0], rk_mem[1]};
                            rnd_reg   <= RndW'(1);
                            state_reg <= ST_ROUND;
                        end
                    end
                end
                ST_EXPAND:
                begin
                    win_reg <= {win_reg[223:0], w_new};
                    if (wi_reg[0])
                        rk_mem[wi_reg[WordW-1:1]] <= {whi_reg, w_new};
                    else
                        whi_reg <= w_new;
                    if (wi_reg[2:0] == 3'd0)
                        rcon_reg <= xtime(rcon_reg);
                    wi_reg <= wi_reg + 1'b1;
                    if (wi_reg == WordW'(ExpWords - 1))
                        state_reg <= ST_IDLE;
                end
                ST_ROUND:
                begin
                    st_reg  <= ks;
                    rnd_reg <= rnd_reg + 1'b1;
                    if (rnd_reg == RndW'(ROUND_COUNT))
                        state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    out_reg   <= {ctr_inc[63:0], ctr_inc[127:64],
                                  res_blk[63:0], res_blk[127:64]};
                    ctr_reg   <= ctr_inc;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> state_reg == ST_IDLE && (!m_tvalid || m_tready))
        else $error("accept while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
    a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ROUND |-> rnd_reg != 0) else $error("round index out of range");
`endif

endmodule

// ===== tb/aes256_ctr_checker.sv =====
// Checker for the AES-256 counter-mode keystream block: watches the config,
// request and result channels, predicts each result and compares. Uses aes_ctr_pkg codes.
`timescale 1ns / 1ps

module aes256_ctr_checker
    import aes_ctr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [135:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [255:0] m_tdata,
    output int           fail_count,
    output int           pending_count,
    output int           result_count
);

    localparam logic [7:0] SboxTab [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

    typedef struct packed {
        logic [63:0] counter_low;
        logic [63:0] counter_high;
        logic [63:0] text_low;
        logic [63:0] text_high;
    } keystream_out_t;

    logic [63:0]    key_word [4];
    logic [127:0]   round_key [15];
    logic [127:0]   counter_value;
    keystream_out_t expected_results [$];

    function automatic logic [7:0] gf_double(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] subst_word(input logic [31:0] w);
        return {SboxTab[w[31:24]], SboxTab[w[23:16]], SboxTab[w[15:8]], SboxTab[w[7:0]]};
    endfunction

    // Rebuild the full schedule from the four key words.
    task automatic rebuild_schedule();
        logic [31:0] w [60];
        logic [31:0] t;
        logic [7:0]  rcon;
        rcon = 8'h01;
        for (int i = 0; i < 4; i++) begin
            w[2*i]     = key_word[i][63:32];
            w[2*i + 1] = key_word[i][31:0];
        end
        for (int i = 8; i < 60; i++) begin
            t = w[i-1];
            if (i % 8 == 0) begin
                t = subst_word({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
                rcon = gf_double(rcon);
            end else if (i % 8 == 4) begin
                t = subst_word(t);
            end
            w[i] = w[i-8] ^ t;
        end
        for (int r = 0; r < 15; r++)
            round_key[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    endtask

    // Byte j of a block sits at bits [127-8j -: 8].
    function automatic logic [127:0] cipher_block(input logic [127:0] blk);
        logic [127:0] s, t;
        logic [7:0]   a0, a1, a2, a3, x;
        s = blk ^ round_key[0];
        for (int r = 1; r <= 14; r++) begin
            for (int c = 0; c < 4; c++)
                for (int b = 0; b < 4; b++)
                    t[127 - 8*(c*4 + b) -: 8] = SboxTab[s[127 - 8*(((c + b) & 3)*4 + b) -: 8]];
            s = t;
            if (r < 14) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = t[127 - 32*c -: 8];
                    a1 = t[119 - 32*c -: 8];
                    a2 = t[111 - 32*c -: 8];
                    a3 = t[103 - 32*c -: 8];
                    x  = a0 ^ a1 ^ a2 ^ a3;
                    s[127 - 32*c -: 8] = a0 ^ x ^ gf_double(a0 ^ a1);
                    s[119 - 32*c -: 8] = a1 ^ x ^ gf_double(a1 ^ a2);
                    s[111 - 32*c -: 8] = a2 ^ x ^ gf_double(a2 ^ a3);
                    s[103 - 32*c -: 8] = a3 ^ x ^ gf_double(a3 ^ a0);
                end
            end
            s = s ^ round_key[r];
        end
        return s;
    endfunction

    task automatic predict_keystream(input logic [135:0] req);
        keystream_out_t exp;
        logic [127:0]   mask, stream;
        int unsigned    n;
        n = req[132:128];
        if (n > 16)
            n = 16;
        if (n == 0) begin
            exp.text_high = '0;
            exp.text_low  = '0;
        end else begin
            stream = cipher_block(counter_value);
            mask = '0;
            for (int j = 0; j < 16; j++)
                if (j < n)
                    mask[127 - 8*j -: 8] = 8'hff;
            stream = ({req[63:0], req[127:64]} ^ stream) & mask;
            exp.text_high = stream[127:64];
            exp.text_low  = stream[63:0];
            counter_value = counter_value + 128'd1;
        end
        exp.counter_high = counter_value[127:64];
        exp.counter_low  = counter_value[63:0];
        expected_results.push_back(exp);
    endtask

    task automatic compare_field(input string name, input logic [63:0] want, got);
        if (got !== want) begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        keystream_out_t want;
        if (!rst_n) begin
            for (int i = 0; i < 4; i++)
                key_word[i] = '0;
            for (int r = 0; r < 15; r++)
                round_key[r] = '0;
            counter_value = '0;
            expected_results.delete();
            fail_count   = 0;
            result_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index) inside
                    REG_KEY_WORD_0, REG_KEY_WORD_1, REG_KEY_WORD_2, REG_KEY_WORD_3:
                    begin
                        key_word[cfg_index[1:0]] = cfg_data;
                        rebuild_schedule();
                    end
                    REG_COUNTER_START_HIGH: counter_value[127:64] = cfg_data;
                    REG_COUNTER_START_LOW:  counter_value[63:0]   = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_keystream(s_tdata);
            if (m_tvalid && m_tready) begin
                result_count++;
                if (expected_results.size() == 0) begin
                    $error("result with no request outstanding: %h", m_tdata);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    compare_field("result_high", want.text_high, m_tdata[63:0]);
                    compare_field("result_low", want.text_low, m_tdata[127:64]);
                    compare_field("counter_now_high", want.counter_high, m_tdata[191:128]);
                    compare_field("counter_now_low", want.counter_low, m_tdata[255:192]);
                end
            end
        end
        pending_count = expected_results.size();
    end

endmodule

// ===== tb/tb_aes256_ctr_keystream.sv =====
// Top of the AES-256 CTR keystream testbench: clock, reset, config writes and
// request stimulus. Depends on aes_ctr_pkg, aes256_ctr_keystream and aes256_ctr_checker.
`timescale 1ns / 1ps

module tb_aes256_ctr_keystream
    import aes_ctr_pkg::*;
();

    logic         clk;
    logic         rst_n;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [63:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [255:0] m_tdata;

    int fail_count;
    int pending_count;
    int result_count;
    int send_idle_pct;
    int recv_idle_pct;
    int request_total;

    aes256_ctr_keystream dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    aes256_ctr_checker checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .result_count  (result_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stall the result side at random; re-decided every falling edge.
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Write one register; the caller drops valid after the last write.
    task automatic write_register(input cfg_reg_t idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    // Hold one request until accepted, with a random gap in front of it.
    task automatic send_block(input logic [63:0] hi, lo, input logic [4:0] count);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, count, lo, hi};
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        request_total++;
    endtask

    // Drop valid, wait for every outstanding result, then let key expansion finish.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic load_key_and_counter(input logic [63:0] k0, k1, k2, k3, ch, cl);
        write_register(REG_KEY_WORD_0, k0);
        write_register(REG_KEY_WORD_1, k1);
        write_register(REG_KEY_WORD_2, k2);
        write_register(REG_KEY_WORD_3, k3);
        write_register(REG_COUNTER_START_HIGH, ch);
        write_register(REG_COUNTER_START_LOW, cl);
        cfg_valid <= 1'b0;
        repeat (60) @(negedge clk);
    endtask

    // Mostly nominal counts, some zero and some above sixteen.
    function automatic logic [4:0] pick_count();
        int sel;
        sel = $urandom_range(99);
        if (sel < 6)
            return 5'd0;
        if (sel < 14)
            return 5'($urandom_range(31, 17));
        if (sel < 30)
            return 5'd16;
        return 5'($urandom_range(16, 1));
    endfunction

    initial
    begin
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        request_total = 0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Zero round keys before any key write.
        send_block('0, '0, 5'd16);
        send_block(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 5'd1);
        send_block(rand64(), rand64(), 5'd0);
        drain_results();

        // Standard test key with counter near the low-half wrap.
        load_key_and_counter(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                             64'h1011121314151617, 64'h18191a1b1c1d1e1f,
                             64'h0, 64'hffff_ffff_ffff_fffe);
        for (int n = 0; n <= 17; n++)
            send_block(rand64(), rand64(), 5'(n));
        send_block(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 5'd31);
        drain_results();

        // All-ones key with counter at full wrap.
        load_key_and_counter('1, '1, '1, '1, '1, 64'hffff_ffff_ffff_ffff);
        send_block('0, '0, 5'd16);
        send_block('1, '1, 5'd8);
        send_block(rand64(), rand64(), 5'd9);
        drain_results();

        // Random phases, idling patterns as planned.
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase / 2)
                0: begin send_idle_pct = 34; recv_idle_pct = 82; end
                1: begin send_idle_pct = 82; recv_idle_pct = 34; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            load_key_and_counter(rand64(), rand64(), rand64(), rand64(), rand64(),
                ($urandom_range(1) == 1) ? 64'hffff_ffff_ffff_ffff - 64'($urandom_range(40))
                                         : rand64());
            for (int i = 0; i < 180; i++)
                send_block(rand64(), rand64(), pick_count());
            drain_results();
        end

        $display("Covered %0d requests and %0d results over zero, standard, all-ones and",
                 request_total, result_count);
        $display("random keys, counter wraps, all byte counts, and three idling patterns.");
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("FAIL");
        $finish;
    end

endmodule
